### hw/rtl/assert_macros.svh
// Assertion macros used by the port checker in hw/rtl/rcf_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/rcf_pkg.sv
// Types and constants of the RGB 3x3 convolution filter.
// Depends on nothing; the filter modules and the testbench import it.
package rcf_pkg;

    localparam int KS         = 3;
    localparam int NTAPS      = KS * KS;
    localparam int MAX_HEIGHT = 4096;
    localparam int FIFO_DEPTH = 8;

    typedef logic [23:0] pixel_t;
    typedef logic [KS-1:0][KS-1:0][23:0] window_t;
    typedef logic [NTAPS-1:0][7:0] taps_t;
    typedef logic [NTAPS-1:0][15:0] weights_t;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_WEIGHTS_TOP    = 3'd2,
        CFG_WEIGHTS_MIDDLE = 3'd3,
        CFG_WEIGHTS_BOTTOM = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       drain;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [47:0] data;
    } cfg_item_t;

    // Request into the line store stage
    typedef struct packed {
        logic   valid;
        pixel_t pix;
    } line_req_t;

    // Per-item control carried alongside the datapath
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } tag_t;

endpackage

### hw/rtl/rcf_stream_if.sv
// Valid/ready channel used for pixels in, results out and configuration.
// Depends on nothing; payload type set per instance.
interface rcf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/rcf_window.sv
// Two line stores and the 3x3 window register.
// Depends on rcf_pkg.
module rcf_window #(
    parameter int ADDR_W = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rcf_pkg::line_req_t req,
    input  logic [ADDR_W-1:0]  addr,
    output rcf_pkg::window_t   win
);
    import rcf_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    pixel_t upper_mem [DEPTH];
    pixel_t lower_mem [DEPTH];

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    pixel_t            pix_reg;
    logic              fwd_reg;
    pixel_t            fwd_top_reg;
    pixel_t            fwd_mid_reg;
    pixel_t            rd_top_reg;
    pixel_t            rd_mid_reg;
    pixel_t            top_eff;
    pixel_t            mid_eff;
    window_t           win_reg;
    window_t           win_next;

    // Take the values written alongside the read when the same column is read twice in a row
    assign top_eff = fwd_reg ? fwd_top_reg : rd_top_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rd_top_reg <= upper_mem[addr];
            rd_mid_reg <= lower_mem[addr];
        end
        if (s1_valid_reg)
        begin
            upper_mem[addr_reg] <= mid_eff;
            lower_mem[addr_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            addr_reg    <= addr;
            pix_reg     <= req.pix;
            fwd_reg     <= s1_valid_reg && (addr_reg == addr);
            fwd_top_reg <= mid_eff;
            fwd_mid_reg <= pix_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < KS; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_eff;
        win_next[1][2] = mid_eff;
        win_next[2][2] = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

### hw/rtl/rcf_lane.sv
// One colour channel of the nine-tap weighted sum, two register stages.
// Depends on rcf_pkg.
module rcf_lane (
    input  logic              clk,
    input  rcf_pkg::taps_t    taps,
    input  rcf_pkg::weights_t weights,
    output logic [7:0]        result
);
    import rcf_pkg::*;

    logic signed [24:0] prod_reg  [NTAPS];
    logic signed [24:0] prod_next [NTAPS];
    logic signed [28:0] sum;
    logic [7:0]         result_reg;
    logic [7:0]         result_next;

    always_comb
    begin
        for (int i = 0; i < NTAPS; i++)
        begin
            prod_next[i] = $signed({1'b0, taps[i]}) * $signed(weights[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Round half up, then clamp to 0..255
    always_comb
    begin
        sum = 29'sd128;
        for (int i = 0; i < NTAPS; i++)
        begin
            sum = sum + 29'(prod_reg[i]);
        end
        if (sum[28])
        begin
            result_next = 8'd0;
        end
        else if (|sum[27:16])
        begin
            result_next = 8'd255;
        end
        else
        begin
            result_next = sum[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### hw/rtl/rcf_out_fifo.sv
// Result queue that decouples the pipeline from the output handshake.
// Depends on rcf_pkg and rcf_stream_if.
module rcf_out_fifo (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    input  rcf_pkg::out_item_t                       push_data,
    output logic [$clog2(rcf_pkg::FIFO_DEPTH+1)-1:0] count,
    rcf_stream_if.source                             pix_out
);
    import rcf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    out_item_t     mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;

    assign pop             = pix_out.valid && pix_out.ready;
    assign pix_out.valid   = count_reg != '0;
    assign pix_out.payload = mem[rd_ptr_reg];
    assign count           = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/rgb_3x3_convolution_filter.sv
// Top level of the RGB 3x3 convolution filter: counters, registers, lanes.
// Depends on rcf_pkg, rcf_stream_if, rcf_window, rcf_lane, rcf_out_fifo.
//
//  channel   dir   payload                                  transfer
//  pix_in    in    drain, in_red, in_green, in_blue         valid & ready
//  pix_out   out   out_red, out_green, out_blue, frame_end  valid & ready
//  cfg       in    index, data (48 bit)                     valid & ready
//
// One pixel per clock while pix_in.ready is high; results leave through the queue.
// Line stores use one read and one write port; the same column read twice in a
// row is forwarded. Rate is held by an eight-entry result queue with credit.
// pix_in.ready drops only when the queue plus items in flight would overflow.
// Reset clears counters, queue, window and valids and sets size and weights to defaults; line stores are not cleared.
module rgb_3x3_convolution_filter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    rcf_stream_if.sink   pix_in,
    rcf_stream_if.source pix_out,
    rcf_stream_if.sink   cfg
);
    import rcf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int DW     = $clog2(MAX_WIDTH + 2);
    localparam int QW     = $clog2(FIFO_DEPTH + 1);

    logic [CW-1:0]     w_eff_reg;
    logic [12:0]       h_eff_reg;
    logic [47:0]       wt_top_reg;
    logic [47:0]       wt_mid_reg;
    logic [47:0]       wt_bot_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [11:0]       row_reg;
    logic [DW-1:0]     drain_reg;

    logic              acc;
    logic              cfg_wr;
    logic              flushing;
    logic [DW-1:0]     d;
    logic              last;
    logic [ADDR_W-1:0] ic;
    logic [12:0]       ir;
    logic [CW-1:0]     qc;
    logic [12:0]       qr;
    logic              emit;
    logic              interior;
    logic              col_wrap;
    logic              row_wrap;
    logic [12:0]       raw_dim;
    logic [CW-1:0]     w_clamp;
    logic [12:0]       h_clamp;
    pixel_t            pix;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    tag_t              tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    pixel_t            ctr3_reg, ctr4_reg;

    line_req_t         req;
    window_t           win;
    weights_t          wts;
    logic [2:0][47:0]  wrow;
    taps_t             taps [3];
    logic [7:0]        lane_res [3];
    logic [QW-1:0]     q_count;
    logic              push;
    out_item_t         push_data;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;
    assign acc       = pix_in.valid && pix_in.ready;

    // Hold back input while the queue could not take every item in flight
    assign pix_in.ready = (int'(q_count) + int'(v1_reg) + int'(v2_reg) + int'(v3_reg)
                           + int'(v4_reg)) < FIFO_DEPTH;

    assign raw_dim = cfg.payload.data[12:0];

    always_comb
    begin
        if (raw_dim < 13'd3)
        begin
            w_clamp = CW'(3);
        end
        else if (int'(raw_dim) > MAX_WIDTH)
        begin
            w_clamp = CW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = CW'(raw_dim);
        end
        if (raw_dim < 13'd3)
        begin
            h_clamp = 13'd3;
        end
        else if (int'(raw_dim) > MAX_HEIGHT)
        begin
            h_clamp = 13'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = raw_dim;
        end
    end

    // Position of this item in the frame and whether it yields a result
    always_comb
    begin
        flushing = drain_reg != '0;
        d        = drain_reg - 1'b1;
        last     = flushing && (d == DW'(w_eff_reg));
        if (flushing)
        begin
            ic = last ? '0 : d[ADDR_W-1:0];
            ir = last ? h_eff_reg + 13'd1 : h_eff_reg;
        end
        else
        begin
            ic = col_reg;
            ir = 13'(row_reg);
        end
        emit = (ir >= 13'd2) || (ir == 13'd1 && ic != '0);
        if (ic == '0)
        begin
            qc = w_eff_reg - 1'b1;
            qr = ir - 13'd2;
        end
        else
        begin
            qc = CW'(ic) - 1'b1;
            qr = ir - 13'd1;
        end
        interior = (qr != '0) && (qr < h_eff_reg - 13'd1)
                && (qc != '0) && (qc < w_eff_reg - 1'b1);
        col_wrap = (CW'(col_reg) + 1'b1) == w_eff_reg;
        row_wrap = (13'(row_reg) + 13'd1) == h_eff_reg;
    end

    assign pix = pix_in.payload.drain ? '0
               : {pix_in.payload.in_red, pix_in.payload.in_green, pix_in.payload.in_blue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg  <= CW'(640);
            h_eff_reg  <= 13'd480;
            wt_top_reg <= '0;
            wt_mid_reg <= 48'd256;
            wt_bot_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.payload.index)
                CFG_IMAGE_WIDTH:
                begin
                    w_eff_reg <= w_clamp;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    drain_reg <= '0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    h_eff_reg <= h_clamp;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    drain_reg <= '0;
                end
                CFG_WEIGHTS_TOP:    wt_top_reg <= cfg.payload.data;
                CFG_WEIGHTS_MIDDLE: wt_mid_reg <= cfg.payload.data;
                CFG_WEIGHTS_BOTTOM: wt_bot_reg <= cfg.payload.data;
                default:            ;
            endcase
        end
        else if (acc)
        begin
            if (!flushing)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    if (row_wrap)
                    begin
                        row_reg   <= '0;
                        drain_reg <= DW'(1);
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (last)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                drain_reg <= '0;
            end
            else
            begin
                drain_reg <= d + DW'(2);
            end
        end
    end

    assign req.valid = acc;
    assign req.pix   = pix;

    rcf_window #(
        .ADDR_W (ADDR_W)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .addr  (ic),
        .win   (win)
    );

    // Pipeline valids track the window, product and sum stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            tag1_reg <= '{emit: emit, interior: interior, last: last};
        end
        tag2_reg <= tag1_reg;
        tag3_reg <= tag2_reg;
        tag4_reg <= tag3_reg;
        ctr3_reg <= win[1][1];
        ctr4_reg <= ctr3_reg;
    end

    assign wrow = {wt_bot_reg, wt_mid_reg, wt_top_reg};

    always_comb
    begin
        for (int r = 0; r < KS; r++)
        begin
            for (int c = 0; c < KS; c++)
            begin
                wts[r*KS+c]     = wrow[r][16*c +: 16];
                taps[0][r*KS+c] = win[r][c][23:16];
                taps[1][r*KS+c] = win[r][c][15:8];
                taps[2][r*KS+c] = win[r][c][7:0];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        rcf_lane u_lane (
            .clk     (clk),
            .taps    (taps[k]),
            .weights (wts),
            .result  (lane_res[k])
        );
    end

    // Merge the lanes, or pass the centre pixel on the border
    assign push = v4_reg && tag4_reg.emit;

    always_comb
    begin
        if (tag4_reg.interior)
        begin
            push_data.out_red   = lane_res[0];
            push_data.out_green = lane_res[1];
            push_data.out_blue  = lane_res[2];
        end
        else
        begin
            push_data.out_red   = ctr4_reg[23:16];
            push_data.out_green = ctr4_reg[15:8];
            push_data.out_blue  = ctr4_reg[7:0];
        end
        push_data.frame_end = tag4_reg.last;
    end

    rcf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (q_count),
        .pix_out   (pix_out)
    );

endmodule

### hw/rtl/rcf_checker.sv
// Port-level checks on the filter top level, attached by bind.
// Depends on rcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcf_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rcf_pkg::out_item_t out_data,
    input logic               cfg_ready
);
    import rcf_pkg::*;

    logic out_stall;

    assign out_stall = out_valid && !out_ready;

    `RCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
    `RCF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_data))
    `RCF_ASSERT_IMPL(a_empty_after_reset, clk, rst_n, !$past(rst_n), !out_valid)
    `RCF_ASSERT_IMPL(a_cfg_always_ready, clk, rst_n, in_valid || !in_valid || in_ready, cfg_ready)

endmodule

bind rgb_3x3_convolution_filter rcf_port_checker u_rcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_data  (pix_out.payload),
    .cfg_ready (cfg.ready)
);

### tb/sv/rcf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RGB 3x3 convolution filter: predicts each result from the
// pixel and configuration transfers and checks the result channel. Uses rcf_pkg.
module rcf_checker
    import rcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_item_t cfg_data,
    output int        fails,
    output int        pending
);
    localparam int STORE_DEPTH = 4096;

    logic [12:0] width_reg, height_reg;
    logic [47:0] weight_row [3];
    logic [23:0] upper_line [STORE_DEPTH];
    logic [23:0] lower_line [STORE_DEPTH];
    logic [23:0] win [3][3];
    int unsigned col_pos, row_pos, flush_pos;
    out_item_t   expected_pixels [$];

    assign pending = expected_pixels.size();

    function automatic int unsigned clamp_size(logic [12:0] raw, int unsigned top);
        int unsigned v;
        v = raw;
        if (v < 3) v = 3;
        if (v > top) v = top;
        return v;
    endfunction

    // Weighted sum of one channel, rounded half up, saturated to 0..255
    function automatic logic [7:0] conv_channel(int shift);
        longint acc;
        longint px;
        logic signed [15:0] wt;
        acc = 128;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                px = (win[r][c] >> shift) & 24'hFF;
                wt = weight_row[r][16*c +: 16];
                acc += px * longint'(wt);
            end
        if (acc < 0) return 8'd0;
        acc = acc >>> 8;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    task automatic filter_pixel(in_item_t it);
        int unsigned w, h, ic, ir, d, qr, qc;
        logic [23:0] px, up, mid;
        logic        flushing, last, interior;
        out_item_t   res;
        w = clamp_size(width_reg, STORE_DEPTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        flushing = flush_pos != 0;
        last = 1'b0;
        d = 0;
        px = it.drain ? 24'd0 : {it.in_red, it.in_green, it.in_blue};
        if (!flushing)
        begin
            ic = (col_pos < w) ? col_pos : 0;
            ir = (row_pos < h) ? row_pos : 0;
        end
        else
        begin
            d = flush_pos - 1;
            if (d > w) d = w;
            last = (d == w);
            ir = last ? h + 1 : h;
            ic = last ? 0 : d;
        end
        up = upper_line[ic];
        mid = lower_line[ic];
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = px;
        upper_line[ic] = mid;
        lower_line[ic] = px;
        if (ir >= 2 || (ir == 1 && ic >= 1))
        begin
            if (ic == 0)
            begin
                qc = w - 1;
                qr = ir - 2;
            end
            else
            begin
                qc = ic - 1;
                qr = ir - 1;
            end
            interior = qr >= 1 && qr + 2 <= h && qc >= 1 && qc + 2 <= w;
            if (interior)
            begin
                res.out_red = conv_channel(16);
                res.out_green = conv_channel(8);
                res.out_blue = conv_channel(0);
            end
            else
            begin
                res.out_red = win[1][1][23:16];
                res.out_green = win[1][1][15:8];
                res.out_blue = win[1][1][7:0];
            end
            res.frame_end = last;
            expected_pixels.push_back(res);
        end
        if (!flushing)
        begin
            ic++;
            if (ic >= w)
            begin
                ic = 0;
                ir++;
                if (ir >= h)
                begin
                    ir = 0;
                    flush_pos = 1;
                end
            end
            col_pos = ic;
            row_pos = ir;
        end
        else if (last)
        begin
            col_pos = 0;
            row_pos = 0;
            flush_pos = 0;
        end
        else
            flush_pos = d + 2;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = 13'd640;
            height_reg = 13'd480;
            weight_row[0] = '0;
            weight_row[1] = 48'd256;
            weight_row[2] = '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            col_pos = 0;
            row_pos = 0;
            flush_pos = 0;
            fails = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_data.index))
                    CFG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg_data.data[12:0];
                        col_pos = 0;
                        row_pos = 0;
                        flush_pos = 0;
                    end
                    CFG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg_data.data[12:0];
                        col_pos = 0;
                        row_pos = 0;
                        flush_pos = 0;
                    end
                    CFG_WEIGHTS_TOP:    weight_row[0] = cfg_data.data;
                    CFG_WEIGHTS_MIDDLE: weight_row[1] = cfg_data.data;
                    CFG_WEIGHTS_BOTTOM: weight_row[2] = cfg_data.data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                filter_pixel(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result %h", $time, out_data);
                end
                else
                begin
                    out_item_t exp_px;
                    exp_px = expected_pixels.pop_front();
                    if (exp_px.out_red !== out_data.out_red)
                    begin
                        fails++;
                        $display("%0t: out_red expected %h actual %h", $time,
                                 exp_px.out_red, out_data.out_red);
                    end
                    if (exp_px.out_green !== out_data.out_green)
                    begin
                        fails++;
                        $display("%0t: out_green expected %h actual %h", $time,
                                 exp_px.out_green, out_data.out_green);
                    end
                    if (exp_px.out_blue !== out_data.out_blue)
                    begin
                        fails++;
                        $display("%0t: out_blue expected %h actual %h", $time,
                                 exp_px.out_blue, out_data.out_blue);
                    end
                    if (exp_px.frame_end !== out_data.frame_end)
                    begin
                        fails++;
                        $display("%0t: frame_end expected %b actual %b", $time,
                                 exp_px.frame_end, out_data.frame_end);
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the RGB 3x3 convolution filter: frames of pixels
// and flush items, configuration between phases. Uses rcf_pkg, rcf_checker.
module tb;
    import rcf_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fails, pending;
    int   sent_pixels = 0;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;

    rcf_stream_if #(.payload_t(in_item_t))  pix_in_if ();
    rcf_stream_if #(.payload_t(out_item_t)) pix_out_if ();
    rcf_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

    rgb_3x3_convolution_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_if),
        .pix_out (pix_out_if),
        .cfg     (cfg_if)
    );

    rcf_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in_if.valid),
        .in_ready  (pix_in_if.ready),
        .in_data   (pix_in_if.payload),
        .out_valid (pix_out_if.valid),
        .out_ready (pix_out_if.ready),
        .out_data  (pix_out_if.payload),
        .cfg_valid (cfg_if.valid),
        .cfg_ready (cfg_if.ready),
        .cfg_data  (cfg_if.payload),
        .fails     (fails),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #30ms;
        $display("FAILURE");
        $finish;
    end

    // Result side: random stall per transfer, one long hold-off on request
    initial
    begin
        pix_out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            @(negedge clk);
            if (hold_req)
            begin
                pix_out_if.ready <= 1'b0;
                repeat (120) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                pix_out_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pix_out_if.ready <= 1'b1;
            do @(posedge clk); while (!(pix_out_if.valid && pix_out_if.ready));
        end
    end

    task automatic send_pixel(bit flush_item);
        in_item_t it;
        int gap;
        it.drain = flush_item;
        it.in_red = 8'($urandom);
        it.in_green = 8'($urandom);
        it.in_blue = 8'($urandom);
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pix_in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in_if.valid <= 1'b1;
        pix_in_if.payload <= it;
        do @(posedge clk); while (!(pix_in_if.valid && pix_in_if.ready));
        @(negedge clk);
        sent_pixels++;
    endtask

    // Drop valid and let every expected result and any trailing work finish
    task automatic wait_drained();
        pix_in_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [47:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= '{index: idx, data: value};
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [47:0] pick_weights();
        logic [47:0] v;
        logic [15:0] extremes [4];
        extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        case ($urandom_range(0, 3))
            0: v = 48'({$urandom, $urandom});
            1:
            begin
                for (int c = 0; c < 3; c++)
                    v[16*c +: 16] = 16'($urandom_range(0, 512) - 256);
            end
            2: v = 48'(16'($urandom_range(0, 160))) << ($urandom_range(0, 2) * 16);
            default:
            begin
                for (int c = 0; c < 3; c++)
                    v[16*c +: 16] = extremes[$urandom_range(0, 3)];
            end
        endcase
        return v;
    endfunction

    // One frame of w x h pixels and w+1 flush items; noise mixes in black
    // pixels and stray pixels during the flush; cut stops the frame early
    task automatic run_frame(int w, int h, bit noisy, int cut);
        for (int i = 0; i < w * h; i++)
        begin
            if (cut > 0 && i == cut) return;
            send_pixel(noisy && $urandom_range(0, 15) == 0);
        end
        for (int i = 0; i <= w; i++)
            send_pixel(!(noisy && $urandom_range(0, 7) == 0));
    endtask

    task automatic set_size(logic [12:0] w_raw, logic [12:0] h_raw);
        write_reg(CFG_IMAGE_WIDTH, 48'(w_raw));
        write_reg(CFG_IMAGE_HEIGHT, 48'(h_raw));
    endtask

    initial
    begin
        int w, h, cut, target;
        pix_in_if.valid = 1'b0;
        pix_in_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: smallest frame under reset weights, width and height
        // below range, a black pixel inside and a stray pixel in the flush
        set_size(13'd1, 13'd0);
        for (int i = 0; i < 9; i++)
            send_pixel(i == 4);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
        wait_drained();
        write_reg(CFG_WEIGHTS_TOP, 48'h8000_7FFF_FFFF);
        write_reg(CFG_WEIGHTS_MIDDLE, 48'h7FFF_8000_0001);
        write_reg(CFG_WEIGHTS_BOTTOM, 48'h0000_FFFF_7FFF);
        set_size(13'd4, 13'd3);
        run_frame(4, 3, 1'b0, 0);
        wait_drained();

        // Width and height registers at full scale, frames cut short; the
        // result side holds off for a long stretch while pixels keep coming
        calm = 1'b1;
        set_size(13'h1FFF, 13'd3);
        run_frame(4096, 3, 1'b0, 64);
        wait_drained();
        set_size(13'd2, 13'h1FFF);
        hold_req = 1'b1;
        run_frame(3, 4096, 1'b0, 300);
        wait_drained();

        // Random frames
        target = sent_pixels + 1700;
        while (sent_pixels < target)
        begin
            write_reg(CFG_WEIGHTS_TOP, pick_weights());
            write_reg(CFG_WEIGHTS_MIDDLE, pick_weights());
            write_reg(CFG_WEIGHTS_BOTTOM, pick_weights());
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_size(13'(w), 13'(h));
            calm = $urandom_range(0, 3) == 0;
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                calm = 1'b1;
                hold_req = 1'b1;
            end
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : 0;
            run_frame(w, h, $urandom_range(0, 2) == 0, cut);
            if ($urandom_range(0, 5) == 0)
            begin
                // pause mid-stream until every result is out, then go on
                wait_drained();
                run_frame(w, h, 1'b0, 0);
            end
            wait_drained();
        end

        pix_in_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rcf_pkg.sv
hw/rtl/rcf_stream_if.sv
hw/rtl/rcf_window.sv
hw/rtl/rcf_lane.sv
hw/rtl/rcf_out_fifo.sv
hw/rtl/rgb_3x3_convolution_filter.sv
hw/rtl/rcf_checker.sv
tb/sv/rcf_checker.sv
tb/sv/tb.sv
